/* rtl/core/bicv_pkg.sv */
// ----------------------------------------------------------------------------
// bicv_pkg: shared types and constants of the boot image crc32 validator
// request layouts, status codes, register indexes and crc constants
// ----------------------------------------------------------------------------
`default_nettype none

package bicv_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_MAGIC      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_LEN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOAD_ADDR  = 2'd2;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam logic [2:0] STATUS_HEADER_OK    = 3'd0;
  localparam logic [2:0] STATUS_BAD_MAGIC    = 3'd1;
  localparam logic [2:0] STATUS_BAD_HDR_SIZE = 3'd2;
  localparam logic [2:0] STATUS_ENTRY_OFFSET = 3'd3;
  localparam logic [2:0] STATUS_ENTRY_LOAD   = 3'd4;
  localparam logic [2:0] STATUS_ZERO_SIZE    = 3'd5;
  localparam logic [2:0] STATUS_CRC_MISMATCH = 3'd6;
  localparam logic [2:0] STATUS_IMAGE_VALID  = 3'd7;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  typedef struct packed {
    logic        kind;
    logic [63:0] image_base;
    logic [31:0] header_magic;
    logic [31:0] header_length;
    logic [63:0] entry_field;
    logic [63:0] size_field;
    logic [31:0] crc_field;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] entry_out;
    logic [63:0] size_out;
    logic [31:0] computed_crc;
    logic        finished;
  } out_t;

  typedef struct packed {
    logic [31:0] magic_value;
    logic [31:0] header_length_value;
    logic [63:0] load_address;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/bicv_hdr_check.sv */
// ----------------------------------------------------------------------------
// bicv_hdr_check: header field checks
// gives the first failing check as a status code, or header ok
// ----------------------------------------------------------------------------
`default_nettype none

module bicv_hdr_check (
  input  wire bicv_pkg::in_t  hdr,
  input  wire bicv_pkg::cfg_t cfg,
  output logic [2:0]          status
);

  logic [63:0] entry_expect;

  // header end address, wraps at 64 bits
  assign entry_expect = hdr.image_base + {32'd0, hdr.header_length};

  always_comb begin
    priority if (hdr.header_magic != cfg.magic_value) begin
      status = bicv_pkg::STATUS_BAD_MAGIC;
    end else if (hdr.header_length != cfg.header_length_value) begin
      status = bicv_pkg::STATUS_BAD_HDR_SIZE;
    end else if (hdr.entry_field != entry_expect) begin
      status = bicv_pkg::STATUS_ENTRY_OFFSET;
    end else if (hdr.entry_field != cfg.load_address) begin
      status = bicv_pkg::STATUS_ENTRY_LOAD;
    end else if (hdr.size_field == 64'd0) begin
      status = bicv_pkg::STATUS_ZERO_SIZE;
    end else begin
      status = bicv_pkg::STATUS_HEADER_OK;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bicv_crc_byte.sv */
// ----------------------------------------------------------------------------
// bicv_crc_byte: one byte of reflected crc-32
// eight bit steps of the 0xEDB88320 polynomial, unrolled
// ----------------------------------------------------------------------------
`default_nettype none

module bicv_crc_byte (
  input  wire  [31:0] crc_in,
  input  wire  [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ bicv_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

/* rtl/core/boot_image_crc32_validator.sv */
// ----------------------------------------------------------------------------
// boot_image_crc32_validator: boot image header and kernel crc-32 check
//
// in channel (in_valid / in_stall / in_data) takes header requests
// (kind 0) and kernel byte requests (kind 1); out channel (out_valid /
// out_stall / out_data) returns at most one result per request
// a header request gives an error result (finished set) or a header ok
// result with entry and size; then exactly size bytes are run through a
// reflected crc-32 and the last one gives image valid or crc mismatch
// bytes outside a payload are dropped; a header always restarts the check
// each request passes the input register, then the result register; one
// request per cycle sustained while out_stall allows, set by the single
// byte-wide crc update and the 64-bit entry add and compare
// out_stall holds the result register; once the input register holds a
// request and a result waits, in_stall follows out_stall in the same cycle
// rst (synchronous) clears the valid flags, config and check state, sets
// the crc to all ones, and leaves the block idle; config writes only while idle
// ----------------------------------------------------------------------------
`default_nettype none

module boot_image_crc32_validator (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  bicv_pkg::in_t                in_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output bicv_pkg::out_t                     out_data,
  input  wire                                cfg_write,
  input  wire  [bicv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [bicv_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  bicv_pkg::cfg_t cfg;

  // input register
  logic          s1_valid;
  bicv_pkg::in_t s1;

  // check state
  logic [31:0] running_crc;
  logic [63:0] bytes_left;
  logic [31:0] kernel_crc;
  logic        in_payload;

  // next values
  logic [31:0] running_crc_next;
  logic [63:0] bytes_left_next;
  logic [31:0] kernel_crc_next;
  logic        in_payload_next;
  logic        produces;
  bicv_pkg::out_t result_next;

  logic        out_free;
  logic        advance;
  logic [2:0]  hdr_status;
  logic [31:0] crc_step;
  logic [31:0] crc_final;

  // result register can be loaded when empty or being taken
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bicv_pkg::REG_MAGIC:      cfg.magic_value <= cfg_data[31:0];
        bicv_pkg::REG_HEADER_LEN: cfg.header_length_value <= cfg_data[31:0];
        bicv_pkg::REG_LOAD_ADDR:  cfg.load_address <= cfg_data;
        default: ;  // index beyond the register list, ignored
      endcase
    end
  end

  // input register, one request deep
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1 <= in_data;
    end
  end

  bicv_hdr_check u_hdr_check (
    .hdr    (s1),
    .cfg    (cfg),
    .status (hdr_status)
  );

  bicv_crc_byte u_crc_byte (
    .crc_in  (running_crc),
    .data    (s1.data_byte),
    .crc_out (crc_step)
  );

  assign crc_final = crc_step ^ bicv_pkg::CRC_ONES;

  always_comb begin
    running_crc_next  = running_crc;
    bytes_left_next   = bytes_left;
    kernel_crc_next   = kernel_crc;
    in_payload_next   = in_payload;
    produces          = 1'b0;
    result_next       = '0;
    if (s1.kind == bicv_pkg::KIND_HEADER) begin
      // header restarts the check whatever was running
      running_crc_next = bicv_pkg::CRC_ONES;
      produces         = 1'b1;
      result_next.status = hdr_status;
      if (hdr_status != bicv_pkg::STATUS_HEADER_OK) begin
        in_payload_next      = 1'b0;
        bytes_left_next      = 64'd0;
        kernel_crc_next      = 32'd0;
        result_next.finished = 1'b1;
      end else begin
        in_payload_next       = 1'b1;
        bytes_left_next       = s1.size_field;
        kernel_crc_next       = s1.crc_field;
        result_next.entry_out = s1.entry_field;
        result_next.size_out  = s1.size_field;
      end
    end else if (in_payload) begin
      running_crc_next = crc_step;
      bytes_left_next  = bytes_left - 64'd1;
      // last byte of the kernel
      if (bytes_left == 64'd1) begin
        in_payload_next          = 1'b0;
        produces                 = 1'b1;
        result_next.computed_crc = crc_final;
        result_next.finished     = 1'b1;
        result_next.status       = (crc_final == kernel_crc) ?
                                   bicv_pkg::STATUS_IMAGE_VALID :
                                   bicv_pkg::STATUS_CRC_MISMATCH;
      end
    end
  end

  // state moves only when the request leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc  <= bicv_pkg::CRC_ONES;
      bytes_left   <= 64'd0;
      kernel_crc   <= 32'd0;
      in_payload   <= 1'b0;
    end else if (advance) begin
      running_crc  <= running_crc_next;
      bytes_left   <= bytes_left_next;
      kernel_crc   <= kernel_crc_next;
      in_payload   <= in_payload_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && produces;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produces) begin
      out_data <= result_next;
    end
  end

`ifndef ASSERT_OFF
  // a byte count is left exactly while a payload runs
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    in_payload == (bytes_left != 64'd0))
    else $error("payload flag and byte count disagree");

  // an accepted header opens the payload
  a_header_opens: assert property (@(posedge clk) disable iff (rst)
    advance && s1.kind == bicv_pkg::KIND_HEADER &&
    hdr_status == bicv_pkg::STATUS_HEADER_OK |=> in_payload)
    else $error("header ok did not open the payload");

  // only the header ok result leaves the check open
  a_open_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.finished |->
    out_data.status == bicv_pkg::STATUS_HEADER_OK)
    else $error("unfinished result with a final status");

  // back pressure only with a request held in the input register
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("stall without a held request");
`endif

endmodule

`default_nettype wire

/* verif/boot_image_crc32_validator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boot_image_crc32_validator_test: header check and kernel crc-32 testbench
// drives header and kernel byte requests with random gaps and back pressure,
// predicts every verdict in a scoreboard and compares results field by field
// ----------------------------------------------------------------------------

module boot_image_crc32_validator_test;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_TICKS = 6;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned PHASES       = 5;

  // predicts the verdict of every accepted request and holds the ones still due
  class image_verdicts;
    logic [31:0]    cfg_magic;
    logic [31:0]    cfg_hdr_len;
    logic [63:0]    cfg_load;
    logic [31:0]    crc_acc;
    logic [63:0]    remaining;
    logic [31:0]    want_crc;
    bit             in_image;
    bicv_pkg::out_t due_verdicts[$];
    int unsigned    errors;

    function new();
      cfg_magic   = '0;
      cfg_hdr_len = '0;
      cfg_load    = '0;
      crc_acc     = bicv_pkg::CRC_ONES;
      remaining   = '0;
      want_crc    = '0;
      in_image    = 1'b0;
      errors      = 0;
    endfunction

    // one byte through the reflected crc-32, lsb first
    static function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ bicv_pkg::CRC_POLY) : (r >> 1);
      end
      return r;
    endfunction

    function void set_register(logic [bicv_pkg::CFG_INDEX_W-1:0] index,
                               logic [63:0] value);
      case (index)
        bicv_pkg::REG_MAGIC:      cfg_magic   = value[31:0];
        bicv_pkg::REG_HEADER_LEN: cfg_hdr_len = value[31:0];
        bicv_pkg::REG_LOAD_ADDR:  cfg_load    = value;
        default: ;
      endcase
    endfunction

    function void take_request(bicv_pkg::in_t r);
      bicv_pkg::out_t v;
      v = '0;
      if (r.kind == bicv_pkg::KIND_HEADER) begin
        crc_acc = bicv_pkg::CRC_ONES;
        if (r.header_magic != cfg_magic)
          v.status = bicv_pkg::STATUS_BAD_MAGIC;
        else if (r.header_length != cfg_hdr_len)
          v.status = bicv_pkg::STATUS_BAD_HDR_SIZE;
        else if (r.entry_field != r.image_base + 64'(r.header_length))
          v.status = bicv_pkg::STATUS_ENTRY_OFFSET;
        else if (r.entry_field != cfg_load)
          v.status = bicv_pkg::STATUS_ENTRY_LOAD;
        else if (r.size_field == 64'd0)
          v.status = bicv_pkg::STATUS_ZERO_SIZE;
        else
          v.status = bicv_pkg::STATUS_HEADER_OK;
        if (v.status == bicv_pkg::STATUS_HEADER_OK) begin
          in_image    = 1'b1;
          remaining   = r.size_field;
          want_crc    = r.crc_field;
          v.entry_out = r.entry_field;
          v.size_out  = r.size_field;
        end else begin
          in_image   = 1'b0;
          remaining  = '0;
          want_crc   = '0;
          v.finished = 1'b1;
        end
        due_verdicts.push_back(v);
      end else if (in_image) begin
        crc_acc   = crc_next(crc_acc, r.data_byte);
        remaining = remaining - 64'd1;
        if (remaining == 64'd0) begin
          in_image       = 1'b0;
          v.computed_crc = crc_acc ^ bicv_pkg::CRC_ONES;
          v.status       = (v.computed_crc == want_crc) ?
                           bicv_pkg::STATUS_IMAGE_VALID :
                           bicv_pkg::STATUS_CRC_MISMATCH;
          v.finished     = 1'b1;
          due_verdicts.push_back(v);
        end
      end
    endfunction

    function void match_verdict(bicv_pkg::out_t got);
      bicv_pkg::out_t want;
      if (due_verdicts.size() == 0) begin
        $error("result with no request waiting: status %0d", got.status);
        errors++;
        return;
      end
      want = due_verdicts.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.entry_out !== want.entry_out) begin
        $error("entry_out: expected %h, actual %h", want.entry_out, got.entry_out);
        errors++;
      end
      if (got.size_out !== want.size_out) begin
        $error("size_out: expected %h, actual %h", want.size_out, got.size_out);
        errors++;
      end
      if (got.computed_crc !== want.computed_crc) begin
        $error("computed_crc: expected %h, actual %h", want.computed_crc,
               got.computed_crc);
        errors++;
      end
      if (got.finished !== want.finished) begin
        $error("finished: expected %0d, actual %0d", want.finished, got.finished);
        errors++;
      end
    endfunction

    function void flag_leftovers();
      if (due_verdicts.size() != 0) begin
        $error("%0d results never arrived", due_verdicts.size());
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  bicv_pkg::in_t                    in_data;
  logic                             out_valid;
  logic                             out_stall;
  bicv_pkg::out_t                   out_data;
  logic                             cfg_write;
  logic [bicv_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bicv_pkg::CFG_DATA_W-1:0]  cfg_data;

  image_verdicts sb;
  int unsigned   counted;

  boot_image_crc32_validator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 10);
    else return $urandom_range(20, 40);
  endfunction

  // receiver side: runs of readiness broken by stalls, with some long clean stretches
  initial begin : receiver_stall
    int unsigned run;
    out_stall = 1'b0;
    forever begin
      run = 1 + idle_span();
      if ($urandom_range(0, 19) == 0) run = $urandom_range(50, 200);
      repeat (run) @(negedge clk) out_stall <= 1'b0;
      run = idle_span();
      repeat (run) @(negedge clk) out_stall <= 1'b1;
    end
  end

  // both channels seen at the rising edge; requests feed the predictor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_request(in_data);
      if (out_valid && !out_stall) sb.match_verdict(out_data);
    end
  end

  // all fields random so every bit toggles, then the kind forced
  function automatic bicv_pkg::in_t random_request(logic kind);
    bicv_pkg::in_t r;
    r.kind          = kind;
    r.image_base    = {$urandom, $urandom};
    r.header_magic  = $urandom;
    r.header_length = $urandom;
    r.entry_field   = {$urandom, $urandom};
    r.size_field    = {$urandom, $urandom};
    r.crc_field     = $urandom;
    r.data_byte     = 8'($urandom);
    return r;
  endfunction

  // header that passes every check under the current registers
  function automatic bicv_pkg::in_t good_header(logic [63:0] size, logic [31:0] crc);
    bicv_pkg::in_t h;
    h               = random_request(bicv_pkg::KIND_HEADER);
    h.header_magic  = sb.cfg_magic;
    h.header_length = sb.cfg_hdr_len;
    h.entry_field   = sb.cfg_load;
    h.image_base    = sb.cfg_load - 64'(sb.cfg_hdr_len);
    h.size_field    = size;
    h.crc_field     = crc;
    return h;
  endfunction

  // valid stays high across back-to-back requests; it drops only for a gap
  task automatic send_request(input bicv_pkg::in_t req);
    int unsigned gap;
    gap = idle_span();
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait for every verdict, then let stray bytes clear the pipe
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.due_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // all three registers in a row; 32-bit ones get junk in the upper word
  task automatic apply_config(input logic [31:0] magic, input logic [31:0] hdr_len,
                              input logic [63:0] load);
    logic [63:0] word;
    word = {32'($urandom), magic};
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= bicv_pkg::REG_MAGIC;
    cfg_data  <= word;
    sb.set_register(bicv_pkg::REG_MAGIC, word);
    word = {32'($urandom), hdr_len};
    @(negedge clk);
    cfg_index <= bicv_pkg::REG_HEADER_LEN;
    cfg_data  <= word;
    sb.set_register(bicv_pkg::REG_HEADER_LEN, word);
    @(negedge clk);
    cfg_index <= bicv_pkg::REG_LOAD_ADDR;
    cfg_data  <= load;
    sb.set_register(bicv_pkg::REG_LOAD_ADDR, load);
    @(negedge clk) cfg_write <= 1'b0;
  endtask

  // good header then nbytes of payload; nbytes below size leaves the check open
  task automatic run_image(input logic [63:0] size, input int unsigned nbytes,
                           input bit good_crc);
    logic [7:0]    payload[$];
    logic [31:0]   c;
    bicv_pkg::in_t req;
    c = bicv_pkg::CRC_ONES;
    for (int i = 0; i < nbytes; i++) begin
      payload.push_back(8'($urandom));
      c = image_verdicts::crc_next(c, payload[i]);
    end
    c = c ^ bicv_pkg::CRC_ONES;
    if (!good_crc) c = c ^ (32'd1 << $urandom_range(0, 31));
    send_request(good_header(size, c));
    foreach (payload[i]) begin
      req           = random_request(bicv_pkg::KIND_DATA);
      req.data_byte = payload[i];
      send_request(req);
    end
    counted += 1 + nbytes;
  endtask

  // header broken in exactly the way one error status names
  task automatic send_faulty_header(input logic [2:0] fault);
    bicv_pkg::in_t h;
    h = good_header({$urandom, $urandom} | 64'd1, $urandom);
    case (fault)
      bicv_pkg::STATUS_BAD_MAGIC:    h.header_magic  ^= 32'd1 << $urandom_range(0, 31);
      bicv_pkg::STATUS_BAD_HDR_SIZE: h.header_length ^= 32'd1 << $urandom_range(0, 31);
      bicv_pkg::STATUS_ENTRY_OFFSET: h.image_base    ^= 64'd1 << $urandom_range(0, 63);
      bicv_pkg::STATUS_ENTRY_LOAD: begin
        h.entry_field = {$urandom, $urandom};
        h.image_base  = h.entry_field - 64'(h.header_length);
      end
      default:                       h.size_field = 64'd0;
    endcase
    send_request(h);
    counted++;
  endtask

  initial begin : stimulus
    int unsigned   r;
    int unsigned   size;
    bicv_pkg::in_t req;
    sb        = new();
    counted   = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: every header fault, both crc outcomes, abort, idle byte
    apply_config($urandom, 32'd64, 64'hFFFF_FFFF_FFFF_FFC0);
    req           = random_request(bicv_pkg::KIND_DATA);
    req.data_byte = 8'h00;
    send_request(req);
    send_faulty_header(bicv_pkg::STATUS_BAD_MAGIC);
    send_faulty_header(bicv_pkg::STATUS_BAD_HDR_SIZE);
    send_faulty_header(bicv_pkg::STATUS_ENTRY_OFFSET);
    send_faulty_header(bicv_pkg::STATUS_ENTRY_LOAD);
    send_faulty_header(bicv_pkg::STATUS_ZERO_SIZE);
    run_image(64'd1, 1, 1'b1);
    run_image(64'd3, 3, 1'b0);
    // largest size, two bytes, then a new header aborts it
    run_image(64'hFFFF_FFFF_FFFF_FFFF, 2, 1'b1);
    req           = good_header(64'd1, 32'h2D02EF8D);
    send_request(req);
    req           = random_request(bicv_pkg::KIND_DATA);
    req.data_byte = 8'hFF;
    send_request(req);
    settle();

    // header length at its top so image base plus length wraps past 2^64
    apply_config(32'd0, 32'hFFFF_FFFF, 64'd0);
    run_image(64'd2, 2, 1'b1);
    send_faulty_header(bicv_pkg::STATUS_ENTRY_LOAD);
    settle();

    counted = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       apply_config($urandom, $urandom_range(0, 4096), {$urandom, $urandom});
        1:       apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        2:       apply_config(32'd0, 32'd0, 64'd0);
        default: apply_config($urandom, $urandom, {$urandom, $urandom});
      endcase
      while (counted < (phase + 1) * RANDOM_ITEMS / PHASES) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          size = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                              : $urandom_range(9, 48);
          run_image(64'(size), size, 1'($urandom_range(0, 1)));
        end else if (r < 70) begin
          // open a check and leave it short; the next header cuts it off
          if ($urandom_range(0, 1) == 1) begin
            run_image({$urandom, $urandom} | 64'h100, $urandom_range(0, 8), 1'b1);
          end else begin
            size = $urandom_range(2, 12);
            run_image(64'(size), $urandom_range(0, size - 1), 1'b1);
          end
        end else if (r < 90) begin
          send_faulty_header(3'($urandom_range(bicv_pkg::STATUS_BAD_MAGIC,
                                               bicv_pkg::STATUS_ZERO_SIZE)));
          repeat ($urandom_range(0, 2)) send_request(random_request(bicv_pkg::KIND_DATA));
        end else if (r < 95) begin
          send_request(random_request(bicv_pkg::KIND_HEADER));
          counted++;
        end else begin
          send_request(random_request(bicv_pkg::KIND_DATA));
        end
        // sender holds off until the block has answered everything
        if ($urandom_range(0, 99) < 3) settle();
      end
      settle();
    end

    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/bicv_pkg.sv
rtl/core/bicv_hdr_check.sv
rtl/core/bicv_crc_byte.sv
rtl/core/boot_image_crc32_validator.sv
verif/boot_image_crc32_validator_test.sv
